FILE: design/tpac_pkg.sv
// ----------------------------------------------------------------------------
// Triac phase-angle controller package
// Shared widths, command codes and the level-to-delay lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package tpac_pkg;

  localparam int DefaultChannels = 8;

  localparam int CmdW       = 2;
  localparam int ChanW      = 3;
  localparam int LevelW     = 8;
  localparam int GateW      = 8;
  localparam int CountW     = 8;
  localparam int CfgChanW   = 4;
  localparam int CfgDataW   = 8;
  localparam int CfgIndexW  = 1;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 16;

  localparam logic [LevelW-1:0] LevelMax     = 8'd165;
  localparam logic [CountW-1:0] DelayAtReset = 8'd167;
  localparam logic [CountW-1:0] PulseAtReset = 8'd10;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK = 2'd0,
    CMD_ZERO = 2'd1,
    CMD_SET  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_CHANNELS_IN_USE  = 1'd0,
    REG_GATE_PULSE_TICKS = 1'd1
  } reg_index_t;

  localparam logic [CountW-1:0] DelayTable [0:165] = '{
    8'd167, 8'd146, 8'd145, 8'd145, 8'd144, 8'd143, 8'd143, 8'd142, 8'd141, 8'd141,
    8'd140, 8'd139, 8'd139, 8'd138, 8'd137, 8'd137, 8'd136, 8'd136, 8'd135, 8'd134,
    8'd134, 8'd133, 8'd133, 8'd132, 8'd131, 8'd131, 8'd130, 8'd130, 8'd129, 8'd129,
    8'd128, 8'd128, 8'd127, 8'd126, 8'd126, 8'd125, 8'd125, 8'd124, 8'd124, 8'd123,
    8'd123, 8'd122, 8'd121, 8'd121, 8'd120, 8'd120, 8'd119, 8'd119, 8'd118, 8'd118,
    8'd117, 8'd117, 8'd116, 8'd116, 8'd115, 8'd114, 8'd114, 8'd113, 8'd113, 8'd112,
    8'd112, 8'd111, 8'd111, 8'd110, 8'd110, 8'd109, 8'd109, 8'd108, 8'd107, 8'd107,
    8'd106, 8'd106, 8'd105, 8'd105, 8'd104, 8'd104, 8'd103, 8'd103, 8'd102, 8'd101,
    8'd101, 8'd100, 8'd100, 8'd99,  8'd99,  8'd98,  8'd98,  8'd97,  8'd96,  8'd96,
    8'd95,  8'd95,  8'd94,  8'd94,  8'd93,  8'd92,  8'd92,  8'd91,  8'd91,  8'd90,
    8'd90,  8'd89,  8'd88,  8'd88,  8'd87,  8'd86,  8'd86,  8'd85,  8'd85,  8'd84,
    8'd83,  8'd83,  8'd82,  8'd81,  8'd81,  8'd80,  8'd79,  8'd79,  8'd78,  8'd77,
    8'd77,  8'd76,  8'd75,  8'd75,  8'd74,  8'd73,  8'd72,  8'd72,  8'd71,  8'd70,
    8'd69,  8'd68,  8'd68,  8'd67,  8'd66,  8'd65,  8'd64,  8'd64,  8'd63,  8'd62,
    8'd61,  8'd60,  8'd59,  8'd58,  8'd57,  8'd56,  8'd55,  8'd54,  8'd53,  8'd51,
    8'd50,  8'd49,  8'd47,  8'd46,  8'd45,  8'd43,  8'd41,  8'd40,  8'd38,  8'd36,
    8'd33,  8'd31,  8'd27,  8'd23,  8'd18,  8'd0
  };

endpackage

`default_nettype wire

FILE: design/triac_phase_angle_controller_core.sv
// ----------------------------------------------------------------------------
// Triac phase-angle controller core
// Multi-channel gate controller driven by tick, zero-crossing and set commands.
// ----------------------------------------------------------------------------
// Each transaction on the input stream is one command and yields exactly one
// result transaction carrying the gate bits and the level of the addressed
// channel. A zero crossing or a level set goes via ST_DONE to the output
// register. A tick goes via ST_SCAN, where a single delay comparator visits
// channels_in_use channels, limited to CHANNELS, one per cycle, then via
// ST_DONE, skipping ST_SCAN if none. The input is not ready while a command
// is in progress; a finished result waits in the output register without
// blocking the next command. Configuration writes are always accepted.
`default_nettype none

module triac_phase_angle_controller_core
  import tpac_pkg::*;
#(
  parameter int CHANNELS = DefaultChannels
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // command [1:0], channel [4:2], level [12:5], zero fill [15:13]
  input  wire logic [InDataW-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // gate_bits [7:0], channel_level [15:8]
  output logic [OutDataW-1:0]       m_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  localparam int IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CntW  = $clog2(CHANNELS + 1);
  localparam int WideW = (CHANNELS > GateW) ? CHANNELS : GateW;
  localparam logic [4:0] ChanLimit = 5'(CHANNELS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  logic [CfgChanW-1:0] channels_in_use;
  logic [CountW-1:0]   gate_pulse_ticks;
  logic [CountW-1:0]   tick_count;
  logic [CountW-1:0]   phase_delay [CHANNELS];
  logic [LevelW-1:0]   power_level [CHANNELS];
  logic [CHANNELS-1:0] gate_state;

  logic [ChanW-1:0]    ch_reg;
  logic [CntW-1:0]     scan_cnt;
  logic [CntW-1:0]     scan_last;

  cmd_t                in_cmd;
  logic [ChanW-1:0]    in_ch;
  logic [LevelW-1:0]   in_level;
  logic [LevelW-1:0]   level_clamped;
  logic [4:0]          in_ch_ext;
  logic [IdxW-1:0]     in_idx;
  logic                in_ch_ok;
  logic [4:0]          used_ext;
  logic [4:0]          used_lim;
  logic [CntW-1:0]     used_cnt;

  logic [IdxW-1:0]     scan_idx;
  logic [CountW-1:0]   scan_delay;
  logic [CountW:0]     off_point;
  logic                scan_off;
  logic                scan_on;

  logic [4:0]          ch_reg_ext;
  logic [IdxW-1:0]     out_idx;
  logic                out_ch_ok;
  logic [WideW-1:0]    gate_wide;
  logic [LevelW-1:0]   out_level;
  logic                accept;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign in_cmd        = cmd_t'(s_tdata[1:0]);
  assign in_ch         = s_tdata[4:2];
  assign in_level      = s_tdata[12:5];
  assign level_clamped = (in_level > LevelMax) ? LevelMax : in_level;
  assign in_ch_ext     = 5'(in_ch);
  assign in_idx        = in_ch_ext[IdxW-1:0];
  assign in_ch_ok      = (in_ch_ext < ChanLimit);

  assign used_ext  = 5'(channels_in_use);
  assign used_lim  = (used_ext > ChanLimit) ? ChanLimit : used_ext;
  assign used_cnt  = used_lim[CntW-1:0];

  assign scan_idx   = scan_cnt[IdxW-1:0];
  assign scan_delay = phase_delay[scan_idx];
  assign off_point  = {1'b0, scan_delay} + {1'b0, gate_pulse_ticks};
  assign scan_off   = ({1'b0, tick_count} >= off_point);
  assign scan_on    = (tick_count >= scan_delay);

  assign ch_reg_ext = 5'(ch_reg);
  assign out_idx    = ch_reg_ext[IdxW-1:0];
  assign out_ch_ok  = (ch_reg_ext < ChanLimit);
  assign out_level  = out_ch_ok ? power_level[out_idx] : '0;
  assign gate_wide  = WideW'(gate_state);

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use  <= '0;
      gate_pulse_ticks <= PulseAtReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_CHANNELS_IN_USE:  channels_in_use  <= cfg_data[CfgChanW-1:0];
        REG_GATE_PULSE_TICKS: gate_pulse_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      gate_state <= '0;
      scan_cnt   <= '0;
      scan_last  <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_delay[i] <= DelayAtReset;
        power_level[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ch_reg <= in_ch;
            if ((in_cmd == CMD_TICK) && (used_cnt != '0)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
            case (in_cmd)
              CMD_TICK: begin
                tick_count <= tick_count + 1'b1;
                scan_cnt   <= '0;
                scan_last  <= used_cnt - 1'b1;
              end
              CMD_ZERO: begin
                tick_count <= '0;
              end
              CMD_SET: begin
                if (in_ch_ok) begin
                  power_level[in_idx] <= level_clamped;
                  phase_delay[in_idx] <= DelayTable[level_clamped];
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_off) begin
            gate_state[scan_idx] <= 1'b0;
          end else if (scan_on) begin
            gate_state[scan_idx] <= 1'b1;
          end
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == scan_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {out_level, gate_wide[GateW-1:0]};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triac phase-angle controller core testbench
// Drives tick, zero-crossing, set and unused commands through the input stream
// and checks every result against a cycle-free gate model or a scripted value.
// ----------------------------------------------------------------------------
// A short scripted part covers reset values, level clamping, the unused
// command code, an oversized channel count, a zero pulse length and a pulse
// that runs past the counter. Random mains half-cycles follow under several
// register settings, with random idling on both streams and two long output
// stalls that back the block up.

module tb_top;
  import tpac_pkg::*;

  localparam int Chans        = DefaultChannels;
  localparam int SettleCycles = Chans + 4;
  localparam int IdleLimit    = 4000;
  localparam int LongHold     = 150;
  localparam int NumPhases    = 7;
  localparam int PhaseItems   = 150;

  typedef struct packed {
    logic [GateW-1:0]  gates;
    logic [LevelW-1:0] level;
  } gate_report_t;

  typedef struct packed {
    logic              is_write;
    reg_index_t        reg_sel;
    logic [7:0]        reg_val;
    cmd_t              op;
    logic [ChanW-1:0]  chan;
    logic [LevelW-1:0] lvl;
    logic              typed;
    logic [GateW-1:0]  want_gates;
    logic [LevelW-1:0] want_level;
  } drive_row_t;

  localparam drive_row_t Script [25] = '{
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_NOP,  3'd5, 8'd255, 1'b1, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_TICK, 3'd0, 8'd0,   1'b1, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_SET,  3'd0, 8'd255, 1'b1, 8'd0, 8'd165},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_SET,  3'd1, 8'd165, 1'b1, 8'd0, 8'd165},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_SET,  3'd2, 8'd166, 1'b1, 8'd0, 8'd165},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_SET,  3'd3, 8'd1,   1'b1, 8'd0, 8'd1},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_SET,  3'd7, 8'd0,   1'b1, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_SET,  3'd4, 8'd164, 1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_ZERO, 3'd3, 8'd0,   1'b1, 8'd0, 8'd1},
    '{1'b1, REG_CHANNELS_IN_USE,  8'd15,  CMD_NOP,  3'd0, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b1, REG_GATE_PULSE_TICKS, 8'd0,   CMD_NOP,  3'd0, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_TICK, 3'd0, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b1, REG_GATE_PULSE_TICKS, 8'd255, CMD_NOP,  3'd0, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_TICK, 3'd1, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_ZERO, 3'd7, 8'd255, 1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_TICK, 3'd4, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b1, REG_CHANNELS_IN_USE,  8'd8,   CMD_NOP,  3'd0, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b1, REG_GATE_PULSE_TICKS, 8'd1,   CMD_NOP,  3'd0, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_TICK, 3'd6, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_TICK, 3'd2, 8'd128, 1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_NOP,  3'd3, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b1, REG_CHANNELS_IN_USE,  8'd0,   CMD_NOP,  3'd0, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_TICK, 3'd5, 8'd0,   1'b0, 8'd0, 8'd0},
    '{1'b0, REG_CHANNELS_IN_USE,  8'd0,   CMD_SET,  3'd6, 8'd85,  1'b0, 8'd0, 8'd0},
    '{1'b1, REG_GATE_PULSE_TICKS, 8'd10,  CMD_NOP,  3'd0, 8'd0,   1'b0, 8'd0, 8'd0}
  };

  localparam int PhaseChans [NumPhases] = '{8, 15, 3, 1, 9, 0, 8};
  localparam int PhasePulse [NumPhases] = '{1, 255, 0, 37, 10, 60, 200};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  logic [CountW-1:0]   tick_cnt;
  logic [CountW-1:0]   delay_of [Chans];
  logic [LevelW-1:0]   level_of [Chans];
  logic                gate_on [Chans];
  logic [CfgChanW-1:0] active_chans;
  logic [7:0]          pulse_len;

  gate_report_t reports_due [$];
  int           mismatches = 0;
  int           delivered = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;

  triac_phase_angle_controller_core #(
    .CHANNELS(Chans)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_gates();
    tick_cnt     = '0;
    active_chans = '0;
    pulse_len    = PulseAtReset;
    for (int i = 0; i < Chans; i++) begin
      delay_of[i] = DelayAtReset;
      level_of[i] = '0;
      gate_on[i]  = 1'b0;
    end
  endfunction

  function automatic gate_report_t apply_command(cmd_t op, logic [ChanW-1:0] chan,
                                                 logic [LevelW-1:0] lvl);
    int           lim;
    int           stop;
    logic [7:0]   clamped;
    gate_report_t rpt;
    case (op)
      CMD_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        lim = (int'(active_chans) > Chans) ? Chans : int'(active_chans);
        for (int i = 0; i < lim; i++) begin
          stop = int'(delay_of[i]) + int'(pulse_len);
          if (int'(tick_cnt) >= stop) begin
            gate_on[i] = 1'b0;
          end else if (tick_cnt >= delay_of[i]) begin
            gate_on[i] = 1'b1;
          end
        end
      end
      CMD_ZERO: begin
        tick_cnt = '0;
      end
      CMD_SET: begin
        clamped = (lvl > LevelMax) ? LevelMax : lvl;
        if (int'(chan) < Chans) begin
          level_of[chan] = clamped;
          delay_of[chan] = DelayTable[clamped];
        end
      end
      default: begin
      end
    endcase
    rpt.gates = '0;
    for (int i = 0; i < Chans && i < GateW; i++) begin
      rpt.gates[i] = gate_on[i];
    end
    rpt.level = (int'(chan) < Chans) ? level_of[chan] : '0;
    return rpt;
  endfunction

  function automatic logic [LevelW-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LevelMax;
      2: return 8'd255;
      3: return 8'($urandom_range(166, 254));
      default: return 8'($urandom_range(0, 165));
    endcase
  endfunction

  task automatic send_cmd(cmd_t op, logic [ChanW-1:0] chan, logic [LevelW-1:0] lvl,
                          bit typed, gate_report_t want);
    int           gap;
    gate_report_t rpt;
    gap = quiet ? 0 : $urandom_range(0, 3);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, lvl, chan, op};
    do @(posedge clk); while (!s_tready);
    rpt = apply_command(op, chan, lvl);
    reports_due.push_back(typed ? want : rpt);
    items_sent++;
  endtask

  task automatic issue(cmd_t op);
    send_cmd(op, 3'($urandom_range(0, 7)), pick_level(), 1'b0, '0);
  endtask

  task automatic quiesce();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t sel, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (sel == REG_CHANNELS_IN_USE) begin
      active_chans = val[CfgChanW-1:0];
    end else begin
      pulse_len = val;
    end
  endtask

  // Output side: random stalls, plus two long holds that back up the block.
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (delivered == 300 || delivered == 1000) begin
        hold = LongHold;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      delivered++;
    end
  end

  always @(posedge clk) begin
    gate_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, got %h", $time, m_tdata);
      end else begin
        want = reports_due.pop_front();
        if (m_tdata[7:0] !== want.gates) begin
          mismatches++;
          $display("%0t: gate_bits expected %h, got %h", $time, want.gates, m_tdata[7:0]);
        end
        if (m_tdata[15:8] !== want.level) begin
          mismatches++;
          $display("%0t: channel_level expected %0d, got %0d", $time, want.level,
                   m_tdata[15:8]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int target;
    int pulse;
    int pick;
    reset_gates();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(Script); r++) begin
      if (Script[r].is_write) begin
        quiesce();
        write_reg(Script[r].reg_sel, Script[r].reg_val);
      end else begin
        send_cmd(Script[r].op, Script[r].chan, Script[r].lvl, Script[r].typed,
                 {Script[r].want_gates, Script[r].want_level});
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      pulse = (p == NumPhases - 1) ? $urandom_range(1, 255) : PhasePulse[p];
      quiesce();
      write_reg(REG_CHANNELS_IN_USE, 8'(PhaseChans[p]));
      write_reg(REG_GATE_PULSE_TICKS, 8'(pulse));
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 6) != 0) begin
          // One mains half-cycle: some level changes, a zero crossing, then ticks with occasional sets and NOPs.
          repeat ($urandom_range(1, 4)) issue(CMD_SET);
          issue(CMD_ZERO);
          repeat ($urandom_range(60, 270)) begin
            pick = $urandom_range(0, 49);
            if (pick == 0) begin
              issue(CMD_NOP);
            end else if (pick < 3) begin
              issue(CMD_SET);
            end else begin
              issue(CMD_TICK);
            end
          end
        end else begin
          repeat ($urandom_range(1, 10)) issue(cmd_t'($urandom_range(0, 3)));
        end
      end
    end

    quiet = 1'b0;
    quiesce();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tpac_pkg.sv
design/triac_phase_angle_controller_core.sv
test/tb_top.sv
